FILE: rtl/core/twc_pkg.sv
package twc_pkg;

  localparam int MAX_UNITS_DEF = 255;
  localparam int FIFO_DEPTH    = 4;
  localparam int MAX_RESULTS   = 3;

  localparam logic [20:0] JOINER     = 21'h0200D;
  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] PLANE1     = 21'h10000;

  // One finished cluster as it leaves the block.
  typedef struct packed {
    logic        last;
    logic        final_cluster;
    logic [7:0]  units;
    logic [20:0] base;
    logic [1:0]  cell_width;
  } rec_t;

  // Results written to the queue by one item, slot 0 first.
  typedef struct packed {
    logic [1:0]       n;
    rec_t [2:0]       recs;
  } push_t;

  function automatic logic in_range(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_mark(logic [20:0] c);
    return in_range(c, 21'h0300, 21'h036F) || in_range(c, 21'h0483, 21'h0489)
        || in_range(c, 21'h0591, 21'h05BD) || in_range(c, 21'h0610, 21'h061A)
        || in_range(c, 21'h064B, 21'h065F) || in_range(c, 21'h07A6, 21'h07B0)
        || in_range(c, 21'h0E31, 21'h0E3A) || in_range(c, 21'h0E47, 21'h0E4E)
        || in_range(c, 21'h1AB0, 21'h1AFF) || in_range(c, 21'h1DC0, 21'h1DFF)
        || in_range(c, 21'h20D0, 21'h20FF) || in_range(c, 21'hFE20, 21'hFE2F);
  endfunction

  function automatic logic is_invisible(logic [20:0] c);
    return (c == 21'h200B) || (c == 21'h200C) || (c == JOINER) || (c == 21'h2060)
        || (c == 21'hFEFF) || in_range(c, 21'hFE00, 21'hFE0F)
        || in_range(c, 21'h1F3FB, 21'h1F3FF) || in_range(c, 21'hE0100, 21'hE01EF);
  endfunction

  function automatic logic is_emoji(logic [20:0] c);
    return in_range(c, 21'h1F000, 21'h1FAFF);
  endfunction

  function automatic logic is_double(logic [20:0] c);
    return in_range(c, 21'h1100, 21'h115F) || in_range(c, 21'h2329, 21'h232A)
        || in_range(c, 21'h2E80, 21'hA4CF) || in_range(c, 21'hAC00, 21'hD7A3)
        || in_range(c, 21'hF900, 21'hFAFF) || in_range(c, 21'hFE10, 21'hFE19)
        || in_range(c, 21'hFE30, 21'hFE6F) || in_range(c, 21'hFF00, 21'hFF60)
        || in_range(c, 21'hFFE0, 21'hFFE6) || in_range(c, 21'h20000, 21'h3FFFD);
  endfunction

  function automatic logic [1:0] base_width(logic [20:0] c);
    logic [1:0] w;
    if (c == '0 || is_mark(c) || is_invisible(c)) begin
      w = 2'd0;
    end else if (c < 21'h20 || in_range(c, 21'h7F, 21'h9F)) begin
      w = 2'd0;
    end else if (in_range(c, 21'hE000, 21'hF8FF) || in_range(c, 21'hF0000, 21'hFFFFD)) begin
      w = 2'd1;
    end else if (in_range(c, 21'h2500, 21'h25FF)) begin
      w = 2'd1;
    end else if (c < 21'h1100) begin
      w = 2'd1;
    end else if (is_double(c) || is_emoji(c)) begin
      w = 2'd2;
    end else begin
      w = 2'd1;
    end
    return w;
  endfunction

endpackage

FILE: rtl/core/twc_core.sv
module twc_core import twc_pkg::*; #(
  parameter int MAX_UNITS = MAX_UNITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tlast,
  input  logic [2:0]  space,
  output push_t       push
);

  localparam int UW = $clog2(MAX_UNITS + 1);

  typedef struct packed {
    logic          open;
    logic [1:0]    width;
    logic [UW-1:0] units;
    logic [20:0]   base;
    logic          join_p;
  } clu_t;

  typedef struct packed {
    clu_t s;
    logic emit;
    rec_t rec;
  } step_t;

  function automatic logic [UW-1:0] sat_add(logic [UW-1:0] a, logic two);
    logic [UW:0] s;
    s = {1'b0, a} + (two ? (UW+1)'(2) : (UW+1)'(1));
    if (s > (UW+1)'(MAX_UNITS)) s = (UW+1)'(MAX_UNITS);
    return s[UW-1:0];
  endfunction

  // One code point against the open cluster: join it, or close and restart.
  function automatic step_t take(clu_t s, logic [20:0] c, logic two);
    step_t r;
    r      = '0;
    r.s    = s;
    if (s.open && s.join_p) begin
      r.s.units  = sat_add(s.units, two);
      if (s.width < 2'd2 && is_emoji(c)) r.s.width = 2'd2;
      r.s.join_p = 1'b0;
    end else if (s.open && c == JOINER) begin
      r.s.units  = sat_add(s.units, two);
      r.s.join_p = 1'b1;
    end else if (s.open && (is_invisible(c) || is_mark(c))) begin
      r.s.units  = sat_add(s.units, two);
    end else begin
      if (s.open) begin
        r.emit           = 1'b1;
        r.rec.cell_width = s.width;
        r.rec.base       = s.base;
        r.rec.units      = 8'(s.units);
      end
      r.s.open   = 1'b1;
      r.s.base   = c;
      r.s.width  = base_width(c);
      r.s.units  = sat_add('0, two);
      r.s.join_p = 1'b0;
    end
    return r;
  endfunction

  logic        in_v;
  logic [15:0] in_unit;
  logic        in_eot;

  clu_t        clu, clu_next;
  logic        held_v, held_v_next;
  logic [15:0] held, held_next;

  logic [1:0]  raw_n;
  rec_t [2:0]  recs;
  logic        fire;

  always_comb begin
    step_t t;
    logic  unit_left;
    logic  is_high;
    logic  is_low;
    t           = '0;
    clu_next    = clu;
    held_v_next = held_v;
    held_next   = held;
    raw_n       = '0;
    recs        = '0;
    unit_left   = 1'b1;
    is_high     = (in_unit >= HIGH_FIRST) && (in_unit <= HIGH_LAST);
    is_low      = (in_unit >= LOW_FIRST) && (in_unit <= LOW_LAST);

    // Held high surrogate: pair it, or let it stand alone.
    if (held_v) begin
      held_v_next = 1'b0;
      if (is_low) begin
        t = take(clu_next, PLANE1 + 21'({held[9:0], in_unit[9:0]}), 1'b1);
        unit_left = 1'b0;
      end else begin
        t = take(clu_next, 21'(held), 1'b0);
      end
      clu_next = t.s;
      if (t.emit) begin
        recs[raw_n] = t.rec;
        raw_n       = raw_n + 2'd1;
      end
    end

    if (unit_left) begin
      if (is_high && !in_eot) begin
        held_next   = in_unit;
        held_v_next = 1'b1;
      end else begin
        t        = take(clu_next, 21'(in_unit), 1'b0);
        clu_next = t.s;
        if (t.emit) begin
          recs[raw_n] = t.rec;
          raw_n       = raw_n + 2'd1;
        end
      end
    end

    // End of text flushes the open cluster and returns to reset.
    if (in_eot) begin
      if (clu_next.open) begin
        recs[raw_n].cell_width    = clu_next.width;
        recs[raw_n].base          = clu_next.base;
        recs[raw_n].units         = 8'(clu_next.units);
        recs[raw_n].final_cluster = 1'b1;
        raw_n                     = raw_n + 2'd1;
      end
      clu_next    = '0;
      held_v_next = 1'b0;
      held_next   = '0;
    end

    if (raw_n != 2'd0) recs[raw_n - 2'd1].last = 1'b1;
  end

  assign fire      = in_v && ({1'b0, raw_n} <= space);
  assign s_tready  = !in_v || fire;
  assign push.n    = fire ? raw_n : 2'd0;
  assign push.recs = recs;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v   <= 1'b0;
      clu    <= '0;
      held_v <= 1'b0;
      held   <= '0;
    end else begin
      if (s_tready) in_v <= s_tvalid;
      if (fire) begin
        clu    <= clu_next;
        held_v <= held_v_next;
        held   <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_unit <= s_tdata;
      in_eot  <= s_tlast;
    end
  end

endmodule

FILE: rtl/core/twc_fifo.sv
module twc_fifo import twc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  push_t       push,
  output logic [2:0]  space,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam int PW = $clog2(FIFO_DEPTH);

  rec_t          mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          pop;
  rec_t          head;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign space    = 3'((PW+1)'(FIFO_DEPTH) - count);
  assign head     = mem[rd_ptr];
  assign m_tdata  = {1'b0, head.units, head.base, head.cell_width};
  assign m_tuser  = head.final_cluster;
  assign m_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count  <= count + (PW+1)'(push.n) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push.n) mem[wr_ptr + PW'(i)] <= push.recs[i];
    end
  end

endmodule

FILE: rtl/core/terminal_cluster_width.sv
// Flow: an accepted beat is registered in the input stage and decoded there; its
//   results are written to the result queue, which offers them on m_tvalid.
// Throughput: one input beat per cycle while the result queue has room for the
//   results of the held beat; an item yields 0 to 3 result beats, one leaves per cycle while m_tready is high.
// Reset: synchronous, active-high rst empties the input stage and the queue and
//   clears surrogate, open-cluster and joiner state.
module terminal_cluster_width import twc_pkg::*; #(
  parameter int MAX_UNITS = MAX_UNITS_DEF   // unit count saturation point
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // code_unit
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cell_width[1:0], base_code_point[22:2],
                                 // unit_count[30:23], zero pad [31]
  output logic        m_tuser,   // final_cluster
  output logic        m_tlast    // last_of_run
);

  // The core holds one input beat, decodes surrogates, and tracks the open
  // cluster. A beat can close up to three clusters (held lone high surrogate,
  // the current unit, end-of-text flush), so the core only retires a beat when
  // the queue has room for all of them. Ready depends on queue occupancy, never
  // on m_tready, so no combinational path runs between the two sides.
  push_t      push;
  logic [2:0] space;

  twc_core #(
    .MAX_UNITS (MAX_UNITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .space    (space),
    .push     (push)
  );

  // Four-entry result queue, up to three writes per cycle, one read.
  twc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/core/twc_chk.sv
module twc_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result beat changed while stalled");

  a_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'b11)
    else $error("cell width out of range");

  // flush at end of text is always the last result of its beat
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("final cluster not marked last of run");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind terminal_cluster_width twc_chk u_twc_chk (.*);
